// ----- design/telnet_option_negotiator_core_assert.svh -----
// Assertion macros used by the telnet negotiator top level.
`ifndef TELNET_OPTION_NEGOTIATOR_CORE_ASSERT_SVH
`define TELNET_OPTION_NEGOTIATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TON_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("telnet negotiator assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TON_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("telnet negotiator assertion failed");

`endif

// ----- design/ton_pkg.sv -----
// Shared types, constants and reply tables of the telnet option negotiator.
package ton_pkg;

  localparam int NAME_MAX  = 45;
  localparam int NTYPES    = 6;
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;

  localparam logic [7:0] OPT_ECHO  = 8'd1;
  localparam logic [7:0] OPT_SGA   = 8'd3;
  localparam logic [7:0] OPT_TTYPE = 8'd24;
  localparam logic [7:0] OPT_LINE  = 8'd34;

  localparam logic [7:0] SUB_IS   = 8'd0;
  localparam logic [7:0] SUB_SEND = 8'd1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd300;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_IAC  = 3'd0,
    PH_CMD  = 3'd1,
    PH_OPT  = 3'd2,
    PH_IS   = 3'd3,
    PH_NAME = 3'd4,
    PH_SE   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    CMD_OPEN    = 3'd0,
    CMD_TREQ    = 3'd1,
    CMD_DONT    = 3'd2,
    CMD_WONT    = 3'd3,
    CMD_ACCEPT  = 3'd4,
    CMD_TIMEOUT = 3'd5
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t  code;
    logic [7:0] opt;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic busy;
  } back_stat_t;

  function automatic logic [3:0] type_len(input logic [2:0] k);
    case (k)
      3'd0:    return 4'd4;
      3'd1:    return 4'd5;
      3'd2:    return 4'd5;
      3'd3:    return 4'd9;
      3'd4:    return 4'd4;
      3'd5:    return 4'd6;
      default: return 4'd0;
    endcase
  endfunction

  // Character i of accepted type k; valid only for i below type_len(k).
  function automatic logic [7:0] type_char(input logic [2:0] k, input logic [3:0] i);
    logic [71:0] s;
    logic [3:0]  pos;
    case (k)
      3'd0:    s = 72'("ANSI");
      3'd1:    s = 72'("XTERM");
      3'd2:    s = 72'("VT100");
      3'd3:    s = 72'("DEC-VT100");
      3'd4:    s = 72'("VTNT");
      3'd5:    s = 72'("CYGWIN");
      default: s = '0;
    endcase
    pos = type_len(k) - 4'd1 - i;
    return s[pos*8 +: 8];
  endfunction

  function automatic logic [3:0] cmd_len(input cmd_code_t code);
    case (code)
      CMD_OPEN:    return 4'd15;
      CMD_TREQ:    return 4'd6;
      CMD_DONT:    return 4'd3;
      CMD_WONT:    return 4'd3;
      default:     return 4'd1;
    endcase
  endfunction

  function automatic logic [7:0] open_byte(input logic [3:0] i);
    case (i)
      4'd0:    return B_IAC;
      4'd1:    return B_WILL;
      4'd2:    return OPT_ECHO;
      4'd3:    return B_IAC;
      4'd4:    return B_DO;
      4'd5:    return OPT_LINE;
      4'd6:    return B_IAC;
      4'd7:    return B_WILL;
      4'd8:    return OPT_SGA;
      4'd9:    return B_IAC;
      4'd10:   return B_DO;
      4'd11:   return OPT_SGA;
      4'd12:   return B_IAC;
      4'd13:   return B_DO;
      4'd14:   return OPT_TTYPE;
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] treq_byte(input logic [3:0] i);
    case (i)
      4'd0:    return B_IAC;
      4'd1:    return B_SB;
      4'd2:    return OPT_TTYPE;
      4'd3:    return SUB_SEND;
      4'd4:    return B_IAC;
      4'd5:    return B_SE;
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] cmd_byte(input cmd_t c, input logic [3:0] i);
    case (c.code)
      CMD_OPEN: return open_byte(i);
      CMD_TREQ: return treq_byte(i);
      CMD_DONT: return (i == 4'd0) ? B_IAC : ((i == 4'd1) ? B_DONT : c.opt);
      CMD_WONT: return (i == 4'd0) ? B_IAC : ((i == 4'd1) ? B_WONT : c.opt);
      default:  return 8'd0;
    endcase
  endfunction

  function automatic logic option_known(input logic [7:0] opt);
    return (opt == OPT_TTYPE) || (opt == OPT_ECHO) || (opt == OPT_SGA) || (opt == OPT_LINE);
  endfunction

endpackage

// ----- design/telnet_option_negotiator_core.sv -----
// Top level of the telnet option negotiator: front end, command queue, back end.
//
// Usage:
//   Input channel (push / full, in_opcode, in_rx_byte): one item per cycle,
//   taken at a clock edge with push high and full low. Opcode 0 starts (or
//   restarts) negotiation, 1 delivers a received byte, 2 is a timer tick.
//   Result channel (empty / pop, out_kind, out_tx_byte, out_last): the oldest
//   result item sits on the ports while empty is low and leaves on pop.
//   out_last marks the final result item caused by one input item.
//   Config: cfg_wr_en writes cfg_wr_data into the timeout register at once.
// Timing:
//   An item is parsed in the cycle it is accepted and its command enters the
//   queue at the accepting edge; with the output free, its first result item
//   is on the ports after the next edge. The front end takes one item per cycle
//   while full is low. The back end drains one result item per cycle while the
//   output is empty or pop is high; a start gives 15 items, a type request 6;
//   the four-entry command queue absorbs bursts, and full rises only when it is
//   full. While full is high every item waits, even one that causes no result.
// Reset: synchronous on rst_n low; negotiation is idle until a start item and
//   the timeout register returns to 300 ticks.
// Stall: while a result waits and pop is low the result register holds, the back end
//   stops, and the queue fills; full then holds off further input.
`include "telnet_option_negotiator_core_assert.svh"

module telnet_option_negotiator_core import ton_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_last
);

  logic       accept;
  logic       cmd_push;
  cmd_t       cmd;
  cmd_t       fifo_head;
  fifo_stat_t fifo_stat;
  logic       fifo_pop;
  back_stat_t back_stat;

  // Stall the whole input while the queue has no room for a command.
  assign full   = fifo_stat.full;
  assign accept = push && !full;

  ton_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .in_opcode   (in_opcode),
    .in_rx_byte  (in_rx_byte),
    .cmd_push    (cmd_push),
    .cmd         (cmd)
  );

  ton_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd),
    .pop       (fifo_pop),
    .head      (fifo_head),
    .stat      (fifo_stat)
  );

  ton_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .fifo_head   (fifo_head),
    .fifo_stat   (fifo_stat),
    .fifo_pop    (fifo_pop),
    .pop         (pop),
    .empty       (empty),
    .out_kind    (out_kind),
    .out_tx_byte (out_tx_byte),
    .out_last    (out_last),
    .stat        (back_stat)
  );

  // A command in expansion always has a byte waiting in the output register.
  `TON_ASSERT_IMP(a_busy_has_output, back_stat.busy, !empty)
  // Accept and timeout results are single items.
  `TON_ASSERT_IMP(a_status_is_last, !empty && out_kind != KIND_BYTE, out_last)
  // A start always leaves a command in the queue.
  `TON_ASSERT_NEXT(a_start_queues, accept && in_opcode == OP_START, !fifo_stat.empty)

endmodule

// ----- design/ton_front.sv -----
// Front end: parses received items, tracks negotiation state, issues reply commands.
module ton_front import ton_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        accept,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_rx_byte,
  output logic        cmd_push,
  output cmd_t        cmd
);

  logic [15:0] timeout_r;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [5:0]  count_r, count_nxt;
  logic [5:0]  match_r, match_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic        fin_r, fin_nxt;
  logic        ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      phase_r   <= PH_IAC;
      held_r    <= '0;
      count_r   <= '0;
      match_r   <= '1;
      tick_r    <= '0;
      fin_r     <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      count_r <= count_nxt;
      match_r <= match_nxt;
      tick_r  <= tick_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    count_nxt = count_r;
    match_nxt = match_r;
    tick_nxt  = tick_r;
    fin_nxt   = fin_r;
    cmd_push  = 1'b0;
    cmd.code  = CMD_OPEN;
    cmd.opt   = in_rx_byte;
    ok        = 1'b0;
    for (int k = 0; k < NTYPES; k++) begin
      if (match_r[k] && (count_r >= 6'(type_len(3'(k))))) begin
        ok = 1'b1;
      end
    end
    if (accept) begin
      case (in_opcode)
        OP_START: begin
          phase_nxt = PH_IAC;
          held_nxt  = '0;
          count_nxt = '0;
          match_nxt = '1;
          tick_nxt  = '0;
          fin_nxt   = 1'b0;
          cmd_push  = 1'b1;
          cmd.code  = CMD_OPEN;
        end
        OP_BYTE: begin
          if (!fin_r) begin
            case (phase_r)
              PH_IAC: begin
                if (in_rx_byte == B_IAC) begin
                  phase_nxt = PH_CMD;
                end
              end
              PH_CMD: begin
                if (in_rx_byte == B_SE) begin
                  phase_nxt = PH_IAC;
                end else begin
                  held_nxt  = in_rx_byte;
                  phase_nxt = PH_OPT;
                end
              end
              PH_OPT: begin
                phase_nxt = PH_IAC;
                if (held_r == B_WILL) begin
                  if (in_rx_byte == OPT_TTYPE) begin
                    cmd_push = 1'b1;
                    cmd.code = CMD_TREQ;
                  end else if (!option_known(in_rx_byte)) begin
                    cmd_push = 1'b1;
                    cmd.code = CMD_DONT;
                  end
                end else if (held_r == B_DO) begin
                  if (!option_known(in_rx_byte)) begin
                    cmd_push = 1'b1;
                    cmd.code = CMD_WONT;
                  end
                end else if (held_r == B_SB && in_rx_byte == OPT_TTYPE) begin
                  phase_nxt = PH_IS;
                end
              end
              PH_IS: begin
                if (in_rx_byte == SUB_IS) begin
                  phase_nxt = PH_NAME;
                  count_nxt = '0;
                  match_nxt = '1;
                end else begin
                  phase_nxt = PH_IAC;
                end
              end
              PH_NAME: begin
                if (in_rx_byte == B_IAC) begin
                  phase_nxt = PH_SE;
                end else if (count_r < 6'(NAME_MAX)) begin
                  // Drop every type whose character at this position differs.
                  for (int k = 0; k < NTYPES; k++) begin
                    if ((count_r < 6'(type_len(3'(k)))) &&
                        (type_char(3'(k), count_r[3:0]) != in_rx_byte)) begin
                      match_nxt[k] = 1'b0;
                    end
                  end
                  count_nxt = count_r + 6'd1;
                end else begin
                  phase_nxt = PH_IAC;
                end
              end
              PH_SE: begin
                phase_nxt = PH_IAC;
                if (in_rx_byte == B_SE) begin
                  cmd_push = 1'b1;
                  if (ok) begin
                    fin_nxt  = 1'b1;
                    cmd.code = CMD_ACCEPT;
                  end else begin
                    cmd.code = CMD_TREQ;
                  end
                end
              end
              default: begin
                phase_nxt = PH_IAC;
              end
            endcase
          end
        end
        OP_TICK: begin
          if (!fin_r) begin
            if (tick_r != 16'hFFFF) begin
              tick_nxt = tick_r + 16'd1;
            end
            if (tick_nxt >= timeout_r) begin
              fin_nxt  = 1'b1;
              cmd_push = 1'b1;
              cmd.code = CMD_TIMEOUT;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- design/ton_cmd_fifo.sv -----
// Short command queue between the parser front end and the reply back end.
module ton_cmd_fifo import ton_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cmd_t       push_data,
  input  logic       pop,
  output cmd_t       head,
  output fifo_stat_t stat
);

  cmd_t                 mem_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMD_CNT_W-1:0] cnt_r;
  logic                 do_push, do_pop;

  assign stat.full  = (cnt_r == CMD_CNT_W'(CMD_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CMD_CNT_W'(do_push) - CMD_CNT_W'(do_pop);
    end
  end

endmodule

// ----- design/ton_back.sv -----
// Back end: expands queued commands into output-register items, one per cycle unless stalled.
module ton_back import ton_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       fifo_head,
  input  fifo_stat_t fifo_stat,
  output logic       fifo_pop,
  input  logic       pop,
  output logic       empty,
  output logic [1:0] out_kind,
  output logic [7:0] out_tx_byte,
  output logic       out_last,
  output back_stat_t stat
);

  logic       busy_r, busy_nxt;
  cmd_t       cmd_r, cmd_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       advance, emit, is_last;
  cmd_t       cur;
  logic [3:0] cur_idx;

  assign empty       = !valid_r;
  assign out_kind    = kind_r;
  assign out_tx_byte = byte_r;
  assign out_last    = last_r;
  assign stat.busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    idx_r  <= idx_nxt;
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  always_comb begin
    advance   = !valid_r || pop;
    cur       = busy_r ? cmd_r : fifo_head;
    cur_idx   = busy_r ? idx_r : 4'd0;
    emit      = advance && (busy_r || !fifo_stat.empty);
    is_last   = (cur_idx == cmd_len(cur.code) - 4'd1);
    busy_nxt  = busy_r;
    cmd_nxt   = cmd_r;
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    kind_nxt  = kind_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    fifo_pop  = emit && !busy_r;
    if (advance) begin
      valid_nxt = emit;
    end
    if (emit) begin
      byte_nxt = cmd_byte(cur, cur_idx);
      last_nxt = is_last;
      case (cur.code)
        CMD_ACCEPT:  kind_nxt = KIND_ACCEPT;
        CMD_TIMEOUT: kind_nxt = KIND_TIMEOUT;
        default:     kind_nxt = KIND_BYTE;
      endcase
      // Hold the command while bytes remain; drop it after the final one.
      busy_nxt = !is_last;
      cmd_nxt  = cur;
      idx_nxt  = cur_idx + 4'd1;
    end
  end

endmodule
